@@ rtl/triple_entry_fifo_with_peek_core_assert.svh @@
// Assertion macros shared by the queue core modules.
`ifndef TRIPLE_ENTRY_FIFO_WITH_PEEK_CORE_ASSERT_SVH
`define TRIPLE_ENTRY_FIFO_WITH_PEEK_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TEFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TEFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tefp_pkg.sv @@
// Shared types and constants for the three-value entry queue.
package tefp_pkg;

  // Default sizing
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int FIELD_WIDTH = 32;
  localparam int POS_WIDTH   = 5;
  localparam int COUNT_WIDTH = 5;
  localparam int CFG_WIDTH   = 5;

  localparam logic [CFG_WIDTH-1:0] CAPACITY_RESET = 5'd16;

  // Actions
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_DISABLED = 3'd4
  } status_code_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_ENABLED  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t                       action;
    logic signed [FIELD_WIDTH-1:0] value_a;
    logic signed [FIELD_WIDTH-1:0] value_b;
    logic signed [FIELD_WIDTH-1:0] value_c;
    logic        [POS_WIDTH-1:0]   position;
  } in_item_t;

  typedef struct packed {
    status_code_t                  status;
    logic signed [FIELD_WIDTH-1:0] read_a;
    logic signed [FIELD_WIDTH-1:0] read_b;
    logic signed [FIELD_WIDTH-1:0] read_c;
    logic        [COUNT_WIDTH-1:0] entry_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // execute the accepted item, launch the memory read
    logic capture;  // form the result from the registered read data
  } dp_cmd_t;

endpackage

@@ rtl/tefp_ctrl.sv @@
// Sequencing state machine for the queue core.
module tefp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tefp_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SEND  = 3'b100
  } ctl_state_t;

  ctl_state_t state, state_next;

  // Advance through execute, fetch and send
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_SEND;
      ST_SEND:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive handshakes and commands
  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_SEND);
  assign cmd.load    = (state == ST_IDLE) && in_valid;
  assign cmd.capture = (state == ST_FETCH);

endmodule

@@ rtl/tefp_datapath.sv @@
// Queue storage, pointers, configuration and result registers.
module tefp_datapath #(
  parameter int DEPTH       = tefp_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = tefp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [tefp_pkg::CFG_WIDTH-1:0]   cfg_data,
  input  tefp_pkg::in_item_t               in_item,
  input  tefp_pkg::dp_cmd_t                cmd,
  output tefp_pkg::out_item_t              out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > tefp_pkg::POS_WIDTH) ? CW : tefp_pkg::POS_WIDTH;
  localparam int PW = LW + 1;
  localparam int EW = 3 * VALUE_WIDTH;

  logic [tefp_pkg::CFG_WIDTH-1:0] capacity;
  logic                           enabled;
  logic [AW-1:0]                  head_index, head_index_next;
  logic [CW-1:0]                  held_count, held_count_next;
  logic [EW-1:0]                  mem [DEPTH];
  logic [EW-1:0]                  mem_q;
  tefp_pkg::status_code_t         status_q, status_next;
  logic                           read_ok_q, read_ok_next;
  logic                           mem_we;
  logic [AW-1:0]                  wr_addr, rd_addr;
  logic [CW-1:0]                  limit;
  logic                           append_ok;
  tefp_pkg::out_item_t            out_q;

  // Fold a sum below twice the depth back into the slot range
  function automatic logic [AW-1:0] wrap_slot(input logic [PW-1:0] s);
    logic [PW-1:0] r;
    r = (s >= PW'(DEPTH)) ? (s - PW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= tefp_pkg::CAPACITY_RESET;
      enabled  <= 1'b1;
    end else if (cfg_we) begin
      unique case (tefp_pkg::cfg_reg_t'(cfg_index))
        tefp_pkg::REG_CAPACITY: capacity <= cfg_data;
        tefp_pkg::REG_ENABLED:  enabled  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate the capacity at the depth
  always_comb begin
    if (int'(capacity) > DEPTH) limit = CW'(DEPTH);
    else                        limit = CW'(capacity);
  end

  assign wr_addr = wrap_slot(PW'(head_index) + PW'(held_count));
  assign rd_addr = wrap_slot(PW'(head_index) + PW'(in_item.position) - PW'(1));

  // Decide the action outcome
  always_comb begin
    status_next     = tefp_pkg::STAT_OK;
    read_ok_next    = 1'b0;
    mem_we          = 1'b0;
    append_ok       = 1'b0;
    head_index_next = head_index;
    held_count_next = held_count;
    if (!enabled) begin
      status_next = tefp_pkg::STAT_DISABLED;
    end else begin
      unique case (in_item.action)
        tefp_pkg::ACT_APPEND: begin
          if (held_count >= limit) begin
            status_next = tefp_pkg::STAT_FULL;
          end else begin
            append_ok       = 1'b1;
            mem_we          = 1'b1;
            held_count_next = held_count + 1'b1;
          end
        end
        tefp_pkg::ACT_REMOVE: begin
          if (held_count == '0) begin
            status_next = tefp_pkg::STAT_EMPTY;
          end else begin
            head_index_next = (head_index == AW'(DEPTH - 1)) ? '0 : head_index + 1'b1;
            held_count_next = held_count - 1'b1;
          end
        end
        tefp_pkg::ACT_READ: begin
          if (in_item.position == '0 || LW'(in_item.position) > LW'(held_count)) begin
            status_next = tefp_pkg::STAT_BADPOS;
          end else begin
            read_ok_next = 1'b1;
          end
        end
        tefp_pkg::ACT_CLEAR: begin
          head_index_next = '0;
          held_count_next = '0;
        end
        default: ;
      endcase
    end
  end

  // Update pointers on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      held_count <= '0;
    end else if (cmd.load) begin
      head_index <= head_index_next;
      held_count <= held_count_next;
    end
  end

  // Hold the outcome until the result is formed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_q  <= status_next;
      read_ok_q <= read_ok_next;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && mem_we) begin
      mem[wr_addr] <= {in_item.value_a[VALUE_WIDTH-1:0],
                       in_item.value_b[VALUE_WIDTH-1:0],
                       in_item.value_c[VALUE_WIDTH-1:0]};
    end
    if (cmd.load) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Form the result; zero the values unless a read succeeded
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_q.status      <= status_q;
      out_q.entry_count <= tefp_pkg::COUNT_WIDTH'(held_count);
      if (read_ok_q) begin
        out_q.read_a <= tefp_pkg::FIELD_WIDTH'(signed'(mem_q[EW-1 -: VALUE_WIDTH]));
        out_q.read_b <= tefp_pkg::FIELD_WIDTH'(signed'(mem_q[2*VALUE_WIDTH-1 -: VALUE_WIDTH]));
        out_q.read_c <= tefp_pkg::FIELD_WIDTH'(signed'(mem_q[VALUE_WIDTH-1:0]));
      end else begin
        out_q.read_a <= '0;
        out_q.read_b <= '0;
        out_q.read_c <= '0;
      end
    end
  end

  assign out_item = out_q;

`include "triple_entry_fifo_with_peek_core_assert.svh"

  `TEFP_ASSERT_NEXT(a_append_grows, cmd.load && append_ok, held_count == $past(held_count) + 1'b1, "append did not grow the count")
  `TEFP_ASSERT_NEXT(a_disabled_holds, cmd.load && !enabled, $stable(held_count) && $stable(head_index), "disabled action changed the queue")
  `TEFP_ASSERT_NOW(a_count_bound, 1'b1, held_count <= CW'(DEPTH), "count exceeds depth")

endmodule

@@ rtl/triple_entry_fifo_with_peek_core.sv @@
// A bounded queue of three-value entries with append, remove, indexed read and clear.
// Each accepted item is executed, which also launches the entry memory read; then the
// read data is registered into the result, and the result is held on the output until
// it is taken. Only then can the next item enter. Entries sit in a single-port-write,
// single-port-read memory addressed as a circular buffer by a head pointer and count;
// the memory needs no clearing after reset. Configuration (capacity, enable) is to be
// written through cfg_we/cfg_index/cfg_data while the queue is idle; the block does
// not enforce this. Values are stored at VALUE_WIDTH bits and read back sign-extended.
module triple_entry_fifo_with_peek_core #(
  parameter int DEPTH       = tefp_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = tefp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [tefp_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tefp_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tefp_pkg::out_item_t            out_item
);

  tefp_pkg::dp_cmd_t cmd;

  // Sequence each item
  tefp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Hold the queue and form results
  tefp_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_item  (out_item)
  );

`include "triple_entry_fifo_with_peek_core_assert.svh"

  `TEFP_ASSERT_NEXT(a_accept_blocks, in_valid && in_ready, !in_ready && !out_valid, "queue took a second item or answered too early")

endmodule

@@ verif/tb_triple_entry_fifo_with_peek_core.sv @@
// Self-checking testbench for the three-value entry queue core.
`timescale 1ns / 1ps

module tb_triple_entry_fifo_with_peek_core;
  import tefp_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int MAX_REPORTS = 10;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [0:0]           cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  // Shadow copy of the queue, updated at each accepted item
  logic [3*FIELD_WIDTH-1:0] shadow_entries [DEPTH_DEF];
  logic [3:0]               shadow_head  = '0;
  logic [COUNT_WIDTH-1:0]   shadow_count = '0;
  logic [CFG_WIDTH-1:0]     shadow_cap   = CAPACITY_RESET;
  logic                     shadow_en    = 1'b1;

  out_item_t pending_replies [$];
  bit        gaps_on      = 1'b0;
  int        error_count  = 0;
  int        items_sent   = 0;
  int        replies_seen = 0;
  int        status_seen [5];
  int        ready_left   = 0;
  int        quiet_cycles = 0;

  triple_entry_fifo_with_peek_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Compute the reply to one action and advance the shadow queue
  function automatic out_item_t apply_queue_action(input in_item_t it);
    out_item_t              rsp;
    logic [COUNT_WIDTH-1:0] lim;
    logic [3:0]             slot;
    rsp = '0;
    rsp.status = STAT_OK;
    lim = (shadow_cap > 5'(DEPTH_DEF)) ? 5'(DEPTH_DEF) : shadow_cap;
    if (!shadow_en) begin
      rsp.status = STAT_DISABLED;
    end else begin
      case (it.action)
        ACT_APPEND: begin
          if (shadow_count >= lim) begin
            rsp.status = STAT_FULL;
          end else begin
            slot = shadow_head + shadow_count[3:0];
            shadow_entries[slot] = {it.value_a, it.value_b, it.value_c};
            shadow_count = shadow_count + 5'd1;
          end
        end
        ACT_REMOVE: begin
          if (shadow_count == 0) begin
            rsp.status = STAT_EMPTY;
          end else begin
            shadow_head = shadow_head + 4'd1;
            shadow_count = shadow_count - 5'd1;
          end
        end
        ACT_READ: begin
          if (it.position == 0 || it.position > shadow_count) begin
            rsp.status = STAT_BADPOS;
          end else begin
            slot = shadow_head + 4'(it.position - 5'd1);
            {rsp.read_a, rsp.read_b, rsp.read_c} = shadow_entries[slot];
          end
        end
        default: begin
          shadow_head = '0;
          shadow_count = '0;
        end
      endcase
    end
    rsp.entry_count = shadow_count;
    return rsp;
  endfunction

  function automatic in_item_t make_item(input action_t act, input logic [4:0] pos,
                                         input logic [31:0] va, input logic [31:0] vb,
                                         input logic [31:0] vc);
    in_item_t it;
    it.action   = act;
    it.value_a  = va;
    it.value_b  = vb;
    it.value_c  = vc;
    it.position = pos;
    return it;
  endfunction

  // Random word with a bias toward the signed extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Offer one item, hold it until accepted, then record its expected reply
  task automatic send_item(input in_item_t it);
    int        gap;
    int        r;
    out_item_t rsp;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(99);
      if (r >= 92) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    rsp = apply_queue_action(it);
    pending_replies.push_back(rsp);
    status_seen[int'(rsp.status)]++;
    items_sent++;
  endtask

  // Drop valid and wait until every reply is back and the core has settled
  task automatic drain_queue();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) shadow_cap = val;
    else shadow_en = val[0];
    @(posedge clk);
  endtask

  // Random items; append_pct steers the queue toward full or empty
  task automatic run_random(input int n, input int append_pct);
    action_t    act;
    logic [4:0] pos;
    int         r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 3) act = ACT_CLEAR;
      else if (r < 3 + append_pct) act = ACT_APPEND;
      else if ($urandom_range(99) < 40) act = ACT_REMOVE;
      else act = ACT_READ;
      r = $urandom_range(9);
      if (r == 0) pos = '0;
      else if (r == 1 || shadow_count == 0) pos = 5'($urandom_range(0, 31));
      else pos = 5'($urandom_range(1, shadow_count));
      send_item(make_item(act, pos, rand_word(), rand_word(), rand_word()));
    end
  endtask

  // Empty-queue errors, extreme values, every read position case, clear
  task automatic test_directed();
    gaps_on = 1'b0;
    send_item(make_item(ACT_REMOVE, 5'd0, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd1, '0, '0, '0));
    send_item(make_item(ACT_APPEND, 5'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
    send_item(make_item(ACT_APPEND, 5'd31, 32'hffff_ffff, 32'h1, 32'h7fff_ffff));
    send_item(make_item(ACT_APPEND, 5'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    send_item(make_item(ACT_READ, 5'd0, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_item(make_item(ACT_READ, 5'd2, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd3, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd4, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd31, '0, '0, '0));
    send_item(make_item(ACT_REMOVE, 5'd0, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd1, '0, '0, '0));
    send_item(make_item(ACT_APPEND, 5'd0, rand_word(), rand_word(), rand_word()));
    send_item(make_item(ACT_READ, 5'd3, '0, '0, '0));
    send_item(make_item(ACT_CLEAR, 5'd0, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd1, '0, '0, '0));
    send_item(make_item(ACT_REMOVE, 5'd0, '0, '0, '0));
    send_item(make_item(ACT_APPEND, 5'd0, 32'h1234_5678, 32'h8765_4321, 32'h0));
    send_item(make_item(ACT_READ, 5'd1, '0, '0, '0));
    drain_queue();
  endtask

  // With the queue disabled every action, clear included, must be refused
  task automatic test_disabled();
    write_reg(REG_ENABLED, 5'd0);
    send_item(make_item(ACT_APPEND, 5'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_item(ACT_REMOVE, 5'd0, '0, '0, '0));
    send_item(make_item(ACT_READ, 5'd1, '0, '0, '0));
    send_item(make_item(ACT_CLEAR, 5'd0, '0, '0, '0));
    drain_queue();
    write_reg(REG_ENABLED, 5'd1);
    send_item(make_item(ACT_READ, 5'd1, '0, '0, '0));
    drain_queue();
  endtask

  // Zero, small, full depth and saturating capacities
  task automatic test_capacity_sweep();
    logic [CFG_WIDTH-1:0] caps [7];
    caps = '{5'd16, 5'd0, 5'd1, 5'd5, 5'd31, 5'd17, 5'd3};
    foreach (caps[i]) begin
      gaps_on = (i % 3) != 2;
      write_reg(REG_CAPACITY, caps[i]);
      run_random(70, 55);
      drain_queue();
    end
  endtask

  // Shrink the capacity under a well-filled queue: held entries stay usable
  task automatic test_capacity_below_count();
    gaps_on = 1'b1;
    write_reg(REG_CAPACITY, 5'd16);
    run_random(40, 85);
    drain_queue();
    write_reg(REG_CAPACITY, 5'd2);
    run_random(60, 40);
    drain_queue();
  endtask

  // Long mixed traffic at random settings, with one disabled stretch
  task automatic test_random_mix();
    int append_pct [4];
    append_pct = '{30, 50, 70, 45};
    foreach (append_pct[i]) begin
      gaps_on = (i != 1);
      write_reg(REG_CAPACITY, 5'($urandom_range(0, 31)));
      if (i == 2) begin
        write_reg(REG_ENABLED, 5'd0);
        run_random(20, 50);
        drain_queue();
        write_reg(REG_ENABLED, 5'd1);
      end
      run_random(230, append_pct[i]);
      drain_queue();
    end
  endtask

  // Output side: ready runs and stalls, short mostly, a few long
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (!gaps_on || $urandom_range(99) < 60) begin
      out_ready  <= 1'b1;
      ready_left = gaps_on ? $urandom_range(0, 5) : 0;
    end else begin
      out_ready  <= 1'b0;
      ready_left = ($urandom_range(99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  // Compare each reply against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_rsp;
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        log_error($sformatf("unexpected reply %p", out_item));
      end else begin
        exp_rsp = pending_replies.pop_front();
        if (out_item.status !== exp_rsp.status ||
            out_item.read_a !== exp_rsp.read_a ||
            out_item.read_b !== exp_rsp.read_b ||
            out_item.read_c !== exp_rsp.read_c ||
            out_item.entry_count !== exp_rsp.entry_count) begin
          log_error($sformatf("reply %0d: expected %p, got %p",
                              replies_seen, exp_rsp, out_item));
        end
      end
    end
  end

  // Stop if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d replies outstanding",
                 quiet_cycles, pending_replies.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_CAPACITY;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_disabled();
    test_capacity_sweep();
    test_capacity_below_count();
    test_random_mix();
    drain_queue();

    if (pending_replies.size() != 0) begin
      log_error($sformatf("%0d replies never arrived", pending_replies.size()));
    end
    $display("Sent %0d items, checked %0d replies, capacities 0 to 31, enable toggled",
             items_sent, replies_seen);
    $display("Statuses: ok %0d, full %0d, empty %0d, bad position %0d, disabled %0d",
             status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
             status_seen[STAT_BADPOS], status_seen[STAT_DISABLED]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tefp_pkg.sv
rtl/tefp_ctrl.sv
rtl/tefp_datapath.sv
rtl/triple_entry_fifo_with_peek_core.sv
verif/tb_triple_entry_fifo_with_peek_core.sv
